[rtl/m4vt_pkg.sv]
// Shared types and constants for the 4x4 matrix-vector transform unit.
`timescale 1ns / 1ps
`default_nettype none

package m4vt_pkg;

   // Matrix dimension and data widths
   localparam int DIM      = 4;
   localparam int WORD_W   = 32;
   localparam int IDX_W    = 2;
   localparam int PROD_W   = 2 * WORD_W;
   localparam int PAIR_W   = PROD_W + 1;
   localparam int SUM_W    = PROD_W + 2;

   // Item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_XFORM = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef word_type [DIM-1:0]       row_type;
   typedef row_type [DIM-1:0]        matrix_type;
   typedef logic signed [SUM_W-1:0]  sum_type;
   typedef sum_type [DIM-1:0]        sum_vec_type;

   // Load enables for the lane pipeline registers
   typedef struct packed {
      logic s1_en;
      logic s2_en;
   } stage_en_type;

   typedef struct packed {
      word_type out_x;
      word_type out_y;
      word_type out_z;
      word_type out_w;
      logic     overflow;
   } result_type;

endpackage

`default_nettype wire

[rtl/m4vt_req_if.sv]
// Request channel: coefficient loads and vector transforms.
`timescale 1ns / 1ps
`default_nettype none

interface m4vt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [m4vt_pkg::IDX_W-1:0] entry_row;
   logic [m4vt_pkg::IDX_W-1:0] entry_col;
   m4vt_pkg::word_type         entry_value;
   m4vt_pkg::word_type         vec_x;
   m4vt_pkg::word_type         vec_y;
   m4vt_pkg::word_type         vec_z;
   m4vt_pkg::word_type         vec_w;

   modport source (
      output valid, opcode, entry_row, entry_col, entry_value,
             vec_x, vec_y, vec_z, vec_w,
      input  ready
   );

   modport sink (
      input  valid, opcode, entry_row, entry_col, entry_value,
             vec_x, vec_y, vec_z, vec_w,
      output ready
   );
endinterface

`default_nettype wire

[rtl/m4vt_rsp_if.sv]
// Response channel: transformed vector and overflow flag.
`timescale 1ns / 1ps
`default_nettype none

interface m4vt_rsp_if;
   logic               valid;
   logic               ready;
   m4vt_pkg::word_type out_x;
   m4vt_pkg::word_type out_y;
   m4vt_pkg::word_type out_z;
   m4vt_pkg::word_type out_w;
   logic               overflow;

   modport source (
      output valid, out_x, out_y, out_z, out_w, overflow,
      input  ready
   );

   modport sink (
      input  valid, out_x, out_y, out_z, out_w, overflow,
      output ready
   );
endinterface

`default_nettype wire

[rtl/m4vt_coef_store.sv]
// Sixteen-entry coefficient store, row-major, cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_coef_store (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic [m4vt_pkg::IDX_W-1:0] wr_row,
   input  wire logic [m4vt_pkg::IDX_W-1:0] wr_col,
   input  wire m4vt_pkg::word_type         wr_value,
   output m4vt_pkg::matrix_type            matrix
);

   localparam int Entries = m4vt_pkg::DIM * m4vt_pkg::DIM;

   m4vt_pkg::word_type store_ff [Entries];

   // Write one coefficient; clear all of them on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Entries; i++) begin
            store_ff[i] <= '0;
         end
      end else if (wr_en) begin
         store_ff[{wr_row, wr_col}] <= wr_value;
      end
   end

   // Present every entry at its fixed place in the matrix
   for (genvar r = 0; r < m4vt_pkg::DIM; r++) begin : g_row
      for (genvar c = 0; c < m4vt_pkg::DIM; c++) begin : g_col
         assign matrix[r][c] = store_ff[r * m4vt_pkg::DIM + c];
      end
   end

endmodule

`default_nettype wire

[rtl/m4vt_lane.sv]
// One row lane: four products, then pair sums, then the exact row total.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_lane (
   input  wire logic                  clock,
   input  wire m4vt_pkg::stage_en_type en,
   input  wire m4vt_pkg::row_type      coef,
   input  wire m4vt_pkg::row_type      vec,
   output m4vt_pkg::sum_type          total
);

   localparam int Dim   = m4vt_pkg::DIM;
   localparam int ProdW = m4vt_pkg::PROD_W;
   localparam int PairW = m4vt_pkg::PAIR_W;
   localparam int SumW  = m4vt_pkg::SUM_W;

   logic signed [ProdW-1:0] prod_ff [Dim];
   logic signed [ProdW-1:0] prod_in [Dim];
   logic signed [PairW-1:0] pair_ff [Dim/2];
   logic signed [PairW-1:0] pair_in [Dim/2];

   // Form each exact product
   always_comb begin
      for (int c = 0; c < Dim; c++) begin
         prod_in[c] = ProdW'($signed(coef[c]) * $signed(vec[c]));
      end
   end

   // Add neighboring products
   always_comb begin
      for (int p = 0; p < Dim / 2; p++) begin
         pair_in[p] = PairW'(prod_ff[2*p]) + PairW'(prod_ff[2*p+1]);
      end
   end

   // Advance the lane registers
   always_ff @(posedge clock) begin
      if (en.s1_en) begin
         prod_ff <= prod_in;
      end
      if (en.s2_en) begin
         pair_ff <= pair_in;
      end
   end

   assign total = SumW'(pair_ff[0]) + SumW'(pair_ff[1]);

endmodule

`default_nettype wire

[rtl/m4vt_merge.sv]
// Merge stage: scale and clamp each lane total, combine overflow, register item.
`timescale 1ns / 1ps
`default_nettype none

module m4vt_merge #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 load_en,
   input  wire m4vt_pkg::sum_vec_type totals,
   output m4vt_pkg::result_type      result
);

   localparam int Dim   = m4vt_pkg::DIM;
   localparam int WordW = m4vt_pkg::WORD_W;
   localparam int SumW  = m4vt_pkg::SUM_W;
   localparam m4vt_pkg::word_type WordMax = {1'b0, {(WordW-1){1'b1}}};
   localparam m4vt_pkg::word_type WordMin = {1'b1, {(WordW-1){1'b0}}};

   m4vt_pkg::sum_type    shifted [Dim];
   m4vt_pkg::word_type   sat_val [Dim];
   logic [Dim-1:0]       clamp;
   m4vt_pkg::result_type result_in;
   m4vt_pkg::result_type result_ff;

   // Drop fraction bits (floor) and clamp to the word range
   always_comb begin
      for (int r = 0; r < Dim; r++) begin
         shifted[r] = totals[r] >>> FRAC_BITS;
         clamp[r]   = !((&shifted[r][SumW-1:WordW-1]) || !(|shifted[r][SumW-1:WordW-1]));
         if (clamp[r]) begin
            sat_val[r] = shifted[r][SumW-1] ? WordMin : WordMax;
         end else begin
            sat_val[r] = shifted[r][WordW-1:0];
         end
      end
      result_in.out_x    = sat_val[0];
      result_in.out_y    = sat_val[1];
      result_in.out_z    = sat_val[2];
      result_in.out_w    = sat_val[3];
      result_in.overflow = |clamp;
   end

   // Hold the finished item until taken
   always_ff @(posedge clock) begin
      if (load_en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

[rtl/matrix4_vector_transform_unit.sv]
// Top level of the 4x4 matrix-vector transform unit.
`timescale 1ns / 1ps
`default_nettype none

// Homogeneous 4x4 transform on signed fixed point with FRAC_BITS fraction
// bits. A load item (opcode OP_LOAD) writes one coefficient and gives no
// result; a transform item gives one vector whose components are the row
// dot products, floored and clamped to 32 bits, with overflow set if any
// component clamped. One item is accepted every cycle while the input is
// not stalled; a transform result goes through the product and pair-sum
// registers of the four row lanes, then the merge output register. When
// the consumer stalls, empty pipeline stages still fill, so input stalls
// only once all three stages hold items. A load just ahead of a transform
// is seen by that transform. The store is cleared by a synchronous reset.
module matrix4_vector_transform_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   m4vt_req_if.sink    req_bus,
   m4vt_rsp_if.source  rsp_bus
);

   localparam int Dim = m4vt_pkg::DIM;

   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;
   logic                   adv1, adv2, adv3;
   logic                   req_fire;
   logic                   load_fire;
   logic                   xform_fire;
   m4vt_pkg::stage_en_type lane_en;
   m4vt_pkg::matrix_type   matrix;
   m4vt_pkg::row_type      vec;
   m4vt_pkg::sum_vec_type  totals;
   m4vt_pkg::result_type   result;

   // Stage advance: a stage moves when it is empty or its successor moves
   assign adv3       = !v3_ff || rsp_bus.ready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_fire   = req_bus.valid && adv1;
   assign load_fire  = req_fire && (req_bus.opcode == m4vt_pkg::OP_LOAD);
   assign xform_fire = req_fire && (req_bus.opcode == m4vt_pkg::OP_XFORM);

   assign lane_en.s1_en = xform_fire;
   assign lane_en.s2_en = adv2 && v1_ff;

   // Track which stages hold a transform item
   always_comb begin
      v1_in = adv1 ? xform_fire : v1_ff;
      v2_in = adv2 ? v1_ff : v2_ff;
      v3_in = adv3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   m4vt_coef_store u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_fire),
      .wr_row   (req_bus.entry_row),
      .wr_col   (req_bus.entry_col),
      .wr_value (req_bus.entry_value),
      .matrix   (matrix)
   );

   assign vec[0] = req_bus.vec_x;
   assign vec[1] = req_bus.vec_y;
   assign vec[2] = req_bus.vec_z;
   assign vec[3] = req_bus.vec_w;

   // One lane per matrix row
   for (genvar r = 0; r < Dim; r++) begin : g_lane
      m4vt_lane u_lane (
         .clock (clock),
         .en    (lane_en),
         .coef  (matrix[r]),
         .vec   (vec),
         .total (totals[r])
      );
   end

   m4vt_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock   (clock),
      .load_en (adv3 && v2_ff),
      .totals  (totals),
      .result  (result)
   );

   assign req_bus.ready    = adv1;
   assign rsp_bus.valid    = v3_ff;
   assign rsp_bus.out_x    = result.out_x;
   assign rsp_bus.out_y    = result.out_y;
   assign rsp_bus.out_z    = result.out_z;
   assign rsp_bus.out_w    = result.out_w;
   assign rsp_bus.overflow = result.overflow;

   // Input stalls only when every stage is occupied
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (v1_ff && v2_ff && v3_ff))
      else $error("input stalled with an empty stage");

   // A new result must come from the pair-sum stage
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(v2_ff))
      else $error("result appeared without a preceding item");

   // A load never enters the lane pipeline
   a_load_no_item : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.opcode == m4vt_pkg::OP_LOAD))
      |=> !v1_ff)
      else $error("load item entered the pipeline");

   // Overflow implies a clamped component
   a_ovf_clamped : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.overflow) |->
         (rsp_bus.out_x == 32'h7FFF_FFFF || rsp_bus.out_x == 32'h8000_0000 ||
          rsp_bus.out_y == 32'h7FFF_FFFF || rsp_bus.out_y == 32'h8000_0000 ||
          rsp_bus.out_z == 32'h7FFF_FFFF || rsp_bus.out_z == 32'h8000_0000 ||
          rsp_bus.out_w == 32'h7FFF_FFFF || rsp_bus.out_w == 32'h8000_0000))
      else $error("overflow set with no clamped component");

endmodule

`default_nettype wire
